// File: src/rau_pkg.sv
package rau_pkg;

  // value range of the fractions; operands are the low VALUE_WIDTH bits, sign extended
  localparam int VALUE_WIDTH = 32;
  localparam int MAG_W       = VALUE_WIDTH;
  localparam int PROD_W      = 2 * VALUE_WIDTH;
  localparam int FIELD_W     = 32;
  localparam int DEN_OUT_W   = 31;
  localparam int CMD_W       = 3;
  localparam int ST_W        = 2;
  localparam int SHIFT_W     = $clog2(PROD_W);
  localparam int CNT_W       = $clog2(PROD_W + 1);

  // 2^(W-1), the magnitude of the most negative value
  localparam logic [PROD_W:0] LIMIT = (PROD_W + 1)'(1) << (VALUE_WIDTH - 1);

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [ST_W-1:0]  st_t;

  localparam cmd_t CMD_NORM  = 3'd0;
  localparam cmd_t CMD_ADD   = 3'd1;
  localparam cmd_t CMD_SUB   = 3'd2;
  localparam cmd_t CMD_MUL   = 3'd3;
  localparam cmd_t CMD_DIV   = 3'd4;
  localparam cmd_t CMD_CMP   = 3'd5;
  localparam cmd_t CMD_FLOOR = 3'd6;

  localparam st_t ST_OK       = 2'd0;
  localparam st_t ST_ZERO_DEN = 2'd1;
  localparam st_t ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] a;
    logic [PROD_W-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] q;
    logic [PROD_W-1:0] r;
  } div_rsp_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] g;
  } gcd_rsp_t;

endpackage

// File: src/rau_divider.sv
// restoring divider, one quotient bit per cycle
module rau_divider import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  unit_req_t req_i,
  output div_rsp_t  rsp_o
);

  logic              busy_r, done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PROD_W-1:0] rem_r, quo_r, dsr_r;
  logic [PROD_W:0]   shifted, diff;
  logic              fits;

  assign shifted = {rem_r, quo_r[PROD_W-1]};
  assign fits    = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        quo_r  <= req_i.a;
        dsr_r  <= req_i.b;
        cnt_r  <= CNT_W'(PROD_W);
      end else if (busy_r) begin
        rem_r <= fits ? diff[PROD_W-1:0] : shifted[PROD_W-1:0];
        quo_r <= {quo_r[PROD_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp_o = '{done: done_r, q: quo_r, r: rem_r};

endmodule

// File: src/rau_gcd.sv
// binary gcd, one shift or subtract per cycle; both operands nonzero
module rau_gcd import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  unit_req_t req_i,
  output gcd_rsp_t  rsp_o
);

  logic              busy_r, done_r;
  logic [PROD_W-1:0] a_r, b_r, g_r;
  logic [SHIFT_W-1:0] k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        a_r    <= req_i.a;
        b_r    <= req_i.b;
        k_r    <= '0;
      end else if (busy_r) begin
        if (a_r == b_r) begin
          g_r    <= a_r << k_r;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else if (!a_r[0] && !b_r[0]) begin
          a_r <= a_r >> 1;
          b_r <= b_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!a_r[0]) begin
          a_r <= a_r >> 1;
        end else if (!b_r[0]) begin
          b_r <= b_r >> 1;
        end else if (a_r > b_r) begin
          a_r <= a_r - b_r;
        end else begin
          b_r <= b_r - a_r;
        end
      end
    end
  end

  assign rsp_o = '{done: done_r, g: g_r};

endmodule

// File: src/rational_arithmetic_unit.sv
// Rational arithmetic unit: takes one command beat with two signed fractions a and b and
// returns one result beat holding the reduced fraction (sign in the numerator, positive
// denominator, zero as 0/1), the floor of a for the floor command, the compare flags and a
// status (zero denominator / divide by zero, or overflow, both returning 0/1). The block
// works on one beat at a time and holds in_stall high from acceptance until the result is
// handed to the output register; a finished result may wait there while the next beat is
// accepted. Processing uses one shared 32x32 multiplier, a binary gcd unit (one shift or
// subtract per cycle) and one restoring divider (used twice to divide numerator and
// denominator by the gcd, and once more up front for floor).
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [FIELD_W-1:0]   in_a_numerator,
  input  logic [FIELD_W-1:0]   in_a_denominator,
  input  logic [FIELD_W-1:0]   in_b_numerator,
  input  logic [FIELD_W-1:0]   in_b_denominator,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [FIELD_W-1:0]   out_result_numerator,
  output logic [DEN_OUT_W-1:0] out_result_denominator,
  output logic [FIELD_W-1:0]   out_whole_part,
  output logic                 out_less,
  output logic                 out_greater,
  output logic                 out_equal,
  output logic [ST_W-1:0]      out_status
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_MUL, S_ADD, S_CMP, S_FDIV, S_RED, S_GCD, S_DIVN, S_DIVD, S_HOLD
  } state_t;

  state_t state_r;

  // operands in sign-magnitude form
  cmd_t             cmd_r;
  logic             an_neg_r, ad_neg_r, bn_neg_r, bd_neg_r;
  logic [MAG_W-1:0] an_mag_r, ad_mag_r, bn_mag_r, bd_mag_r;

  // working fraction and the second addend
  logic              num_neg_r, den_neg_r, t_neg_r;
  logic [PROD_W-1:0] num_mag_r, den_mag_r, t_mag_r;
  logic [PROD_W-1:0] g_r, nm_r;
  logic [FIELD_W-1:0] whole_r;
  logic [1:0]        step_r;

  // result waiting for the output register
  logic [FIELD_W-1:0]   res_num_r, res_whole_r;
  logic [DEN_OUT_W-1:0] res_den_r;
  logic                 res_lt_r, res_gt_r, res_eq_r;
  st_t                  res_st_r;

  // output register
  logic                 out_valid_r;
  logic [FIELD_W-1:0]   out_num_r, out_whole_r;
  logic [DEN_OUT_W-1:0] out_den_r;
  logic                 out_lt_r, out_gt_r, out_eq_r;
  st_t                  out_st_r;

  logic              div_start_r, gcd_start_r;
  logic [PROD_W-1:0] unit_a_r, unit_b_r;
  unit_req_t         div_req, gcd_req;
  div_rsp_t          div_rsp;
  gcd_rsp_t          gcd_rsp;

  rau_divider u_div (.clk(clk), .rst_n(rst_n), .req_i(div_req), .rsp_o(div_rsp));
  rau_gcd     u_gcd (.clk(clk), .rst_n(rst_n), .req_i(gcd_req), .rsp_o(gcd_rsp));

  assign div_req = '{start: div_start_r, a: unit_a_r, b: unit_b_r};
  assign gcd_req = '{start: gcd_start_r, a: unit_a_r, b: unit_b_r};

  function automatic logic [MAG_W:0] split(logic [FIELD_W-1:0] f);
    logic [MAG_W-1:0] v;
    v = f[MAG_W-1:0];
    return {v[MAG_W-1], v[MAG_W-1] ? (MAG_W'(0) - v) : v};
  endfunction

  logic [MAG_W:0] an_s, ad_s, bn_s, bd_s;
  assign an_s = split(in_a_numerator);
  assign ad_s = split(in_a_denominator);
  assign bn_s = split(in_b_numerator);
  assign bd_s = split(in_b_denominator);

  // zero denominator / divide by zero
  logic bad_operand;
  always_comb begin
    bad_operand = 1'b0;
    if (ad_mag_r == '0 && cmd_r <= CMD_FLOOR) bad_operand = 1'b1;
    if (bd_mag_r == '0 && cmd_r >= CMD_ADD && cmd_r <= CMD_CMP) bad_operand = 1'b1;
    if (cmd_r == CMD_DIV && bn_mag_r == '0) bad_operand = 1'b1;
  end

  // shared multiplier, operands picked by command and step
  logic [MAG_W-1:0]  mul_a, mul_b;
  logic              mul_neg, mul_last;
  logic [PROD_W-1:0] mul_p;
  always_comb begin
    mul_a    = an_mag_r;
    mul_b    = bd_mag_r;
    mul_neg  = an_neg_r ^ bd_neg_r;
    mul_last = (step_r == 2'd1);
    case (cmd_r)
      CMD_ADD, CMD_SUB: begin
        mul_last = (step_r == 2'd2);
        case (step_r)
          2'd0: begin
            mul_a = an_mag_r; mul_b = bd_mag_r; mul_neg = an_neg_r ^ bd_neg_r;
          end
          2'd1: begin
            mul_a = bn_mag_r; mul_b = ad_mag_r;
            mul_neg = bn_neg_r ^ ad_neg_r ^ (cmd_r == CMD_SUB);
          end
          default: begin
            mul_a = ad_mag_r; mul_b = bd_mag_r; mul_neg = ad_neg_r ^ bd_neg_r;
          end
        endcase
      end
      CMD_MUL: begin
        if (step_r == 2'd0) begin
          mul_a = an_mag_r; mul_b = bn_mag_r; mul_neg = an_neg_r ^ bn_neg_r;
        end else begin
          mul_a = ad_mag_r; mul_b = bn_mag_r; mul_neg = ad_neg_r ^ bn_neg_r;
          mul_a = ad_mag_r; mul_b = bd_mag_r; mul_neg = ad_neg_r ^ bd_neg_r;
        end
      end
      CMD_CMP: begin
        // both sides over positive denominators: sign of a.n/a.d and of b.n/b.d
        if (step_r == 2'd0) begin
          mul_a = an_mag_r; mul_b = bd_mag_r; mul_neg = an_neg_r ^ ad_neg_r;
        end else begin
          mul_a = bn_mag_r; mul_b = ad_mag_r; mul_neg = bn_neg_r ^ bd_neg_r;
        end
      end
      default: begin
        // divide: a.n*b.d over a.d*b.n
        if (step_r == 2'd0) begin
          mul_a = an_mag_r; mul_b = bd_mag_r; mul_neg = an_neg_r ^ bd_neg_r;
        end else begin
          mul_a = ad_mag_r; mul_b = bn_mag_r; mul_neg = ad_neg_r ^ bn_neg_r;
        end
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // compare in two's complement, products stay below 2^(PROD_W-1)
  logic signed [PROD_W:0] cmp_l, cmp_r;
  assign cmp_l = num_neg_r ? -$signed({1'b0, num_mag_r}) : $signed({1'b0, num_mag_r});
  assign cmp_r = den_neg_r ? -$signed({1'b0, den_mag_r}) : $signed({1'b0, den_mag_r});

  // floor fix-up from the divider's quotient and remainder
  logic              fl_neg, fl_adj, fl_ovf;
  logic [MAG_W-1:0]  fl_rem;
  logic [PROD_W:0]   fl_qpos, fl_qval;
  always_comb begin
    fl_neg  = an_neg_r ^ ad_neg_r;
    fl_rem  = div_rsp.r[MAG_W-1:0];
    fl_adj  = fl_neg && (fl_rem != '0);
    fl_qpos = {1'b0, div_rsp.q} + (PROD_W + 1)'(fl_adj);
    fl_ovf  = fl_neg ? (fl_qpos > LIMIT) : (fl_qpos > LIMIT - 1'b1);
    fl_qval = fl_neg ? ((PROD_W + 1)'(0) - fl_qpos) : fl_qpos;
  end

  // range check and signed numerator of the reduced fraction
  logic              rd_neg, rd_ovf;
  logic [PROD_W:0]   rd_val;
  always_comb begin
    rd_neg = num_neg_r ^ den_neg_r;
    rd_ovf = (rd_neg ? ({1'b0, nm_r} > LIMIT) : ({1'b0, nm_r} > LIMIT - 1'b1))
          || ({1'b0, div_rsp.q} > LIMIT - 1'b1);
    rd_val = rd_neg ? ((PROD_W + 1)'(0) - {1'b0, nm_r}) : {1'b0, nm_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      gcd_start_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      gcd_start_r <= 1'b0;
      // a new result loaded in S_HOLD takes the place of the one leaving
      if (out_valid_r && !out_stall && state_r != S_HOLD) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r    <= in_command;
            an_neg_r <= an_s[MAG_W]; an_mag_r <= an_s[MAG_W-1:0];
            ad_neg_r <= ad_s[MAG_W]; ad_mag_r <= ad_s[MAG_W-1:0];
            bn_neg_r <= bn_s[MAG_W]; bn_mag_r <= bn_s[MAG_W-1:0];
            bd_neg_r <= bd_s[MAG_W]; bd_mag_r <= bd_s[MAG_W-1:0];
            whole_r  <= '0;
            state_r  <= S_START;
          end
        end

        S_START: begin
          step_r      <= '0;
          res_num_r   <= '0;
          res_den_r   <= DEN_OUT_W'(1);
          res_whole_r <= '0;
          res_lt_r    <= 1'b0;
          res_gt_r    <= 1'b0;
          res_eq_r    <= 1'b0;
          res_st_r    <= ST_OK;
          if (bad_operand) begin
            res_st_r <= ST_ZERO_DEN;
            state_r  <= S_HOLD;
          end else begin
            case (cmd_r)
              CMD_NORM: begin
                num_neg_r <= an_neg_r; num_mag_r <= PROD_W'(an_mag_r);
                den_neg_r <= ad_neg_r; den_mag_r <= PROD_W'(ad_mag_r);
                state_r   <= S_RED;
              end
              CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_CMP: state_r <= S_MUL;
              CMD_FLOOR: begin
                unit_a_r    <= PROD_W'(an_mag_r);
                unit_b_r    <= PROD_W'(ad_mag_r);
                div_start_r <= 1'b1;
                state_r     <= S_FDIV;
              end
              default: state_r <= S_HOLD;
            endcase
          end
        end

        S_MUL: begin
          step_r <= step_r + 1'b1;
          if (step_r == 2'd0) begin
            num_neg_r <= mul_neg; num_mag_r <= mul_p;
          end else if (step_r == 2'd1 && (cmd_r == CMD_ADD || cmd_r == CMD_SUB)) begin
            t_neg_r <= mul_neg; t_mag_r <= mul_p;
          end else begin
            den_neg_r <= mul_neg; den_mag_r <= mul_p;
          end
          if (mul_last) begin
            if (cmd_r == CMD_ADD || cmd_r == CMD_SUB) state_r <= S_ADD;
            else if (cmd_r == CMD_CMP)                state_r <= S_CMP;
            else                                      state_r <= S_RED;
          end
        end

        S_ADD: begin
          if (num_neg_r == t_neg_r) begin
            num_mag_r <= num_mag_r + t_mag_r;
          end else if (num_mag_r >= t_mag_r) begin
            num_mag_r <= num_mag_r - t_mag_r;
          end else begin
            num_neg_r <= t_neg_r;
            num_mag_r <= t_mag_r - num_mag_r;
          end
          state_r <= S_RED;
        end

        S_CMP: begin
          res_lt_r <= cmp_l < cmp_r;
          res_gt_r <= cmp_l > cmp_r;
          res_eq_r <= cmp_l == cmp_r;
          state_r  <= S_HOLD;
        end

        S_FDIV: begin
          if (div_rsp.done) begin
            if (fl_ovf) begin
              res_st_r <= ST_OVERFLOW;
              state_r  <= S_HOLD;
            end else begin
              whole_r   <= FIELD_W'(signed'(fl_qval));
              num_neg_r <= 1'b0;
              num_mag_r <= PROD_W'(fl_adj ? (ad_mag_r - fl_rem) : fl_rem);
              den_neg_r <= 1'b0;
              den_mag_r <= PROD_W'(ad_mag_r);
              state_r   <= S_RED;
            end
          end
        end

        S_RED: begin
          if (num_mag_r == '0) begin
            res_whole_r <= whole_r;
            state_r     <= S_HOLD;
          end else begin
            unit_a_r    <= num_mag_r;
            unit_b_r    <= den_mag_r;
            gcd_start_r <= 1'b1;
            state_r     <= S_GCD;
          end
        end

        S_GCD: begin
          if (gcd_rsp.done) begin
            g_r         <= gcd_rsp.g;
            unit_a_r    <= num_mag_r;
            unit_b_r    <= gcd_rsp.g;
            div_start_r <= 1'b1;
            state_r     <= S_DIVN;
          end
        end

        S_DIVN: begin
          if (div_rsp.done) begin
            nm_r        <= div_rsp.q;
            unit_a_r    <= den_mag_r;
            unit_b_r    <= g_r;
            div_start_r <= 1'b1;
            state_r     <= S_DIVD;
          end
        end

        S_DIVD: begin
          if (div_rsp.done) begin
            if (rd_ovf) begin
              res_st_r <= ST_OVERFLOW;
            end else begin
              res_num_r   <= FIELD_W'(signed'(rd_val));
              res_den_r   <= DEN_OUT_W'(div_rsp.q);
              res_whole_r <= whole_r;
            end
            state_r <= S_HOLD;
          end
        end

        S_HOLD: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_num_r   <= res_num_r;
            out_den_r   <= res_den_r;
            out_whole_r <= res_whole_r;
            out_lt_r    <= res_lt_r;
            out_gt_r    <= res_gt_r;
            out_eq_r    <= res_eq_r;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall               = (state_r != S_IDLE);
  assign out_valid              = out_valid_r;
  assign out_result_numerator   = out_num_r;
  assign out_result_denominator = out_den_r;
  assign out_whole_part         = out_whole_r;
  assign out_less               = out_lt_r;
  assign out_greater            = out_gt_r;
  assign out_equal              = out_eq_r;
  assign out_status             = out_st_r;

endmodule

// File: src/rau_checker.sv
module rau_checker import rau_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [CMD_W-1:0]     in_command,
  input logic [FIELD_W-1:0]   in_a_numerator,
  input logic [FIELD_W-1:0]   in_a_denominator,
  input logic [FIELD_W-1:0]   in_b_numerator,
  input logic [FIELD_W-1:0]   in_b_denominator,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [FIELD_W-1:0]   out_result_numerator,
  input logic [DEN_OUT_W-1:0] out_result_denominator,
  input logic [FIELD_W-1:0]   out_whole_part,
  input logic                 out_less,
  input logic                 out_greater,
  input logic                 out_equal,
  input logic [ST_W-1:0]      out_status
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_numerator)
      && $stable(out_result_denominator) && $stable(out_status))
    else $error("result beat changed while stalled");

  // error or overflow returns 0/1 with everything else clear
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_numerator == '0
      && out_result_denominator == DEN_OUT_W'(1) && out_whole_part == '0
      && !out_less && !out_greater && !out_equal)
    else $error("error result not cleared");

  a_den_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_denominator != '0
      && $countones({out_less, out_greater, out_equal}) <= 1)
    else $error("bad denominator or compare flags");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a beat while busy");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the rational arithmetic unit.
// A predictor works out the reduced fraction, floor, compare flags and status for every
// command beat the block accepts; results are checked in order against that queue.
module tb_top;
  import rau_pkg::*;

  localparam int WDOG_LIMIT = 20000;

  typedef struct {
    logic [FIELD_W-1:0]   num;
    logic [DEN_OUT_W-1:0] den;
    logic [FIELD_W-1:0]   whole;
    logic                 lt;
    logic                 gt;
    logic                 eq;
    st_t                  st;
  } frac_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_command = '0;
  logic [FIELD_W-1:0]   in_a_numerator = '0;
  logic [FIELD_W-1:0]   in_a_denominator = '0;
  logic [FIELD_W-1:0]   in_b_numerator = '0;
  logic [FIELD_W-1:0]   in_b_denominator = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [FIELD_W-1:0]   out_result_numerator;
  logic [DEN_OUT_W-1:0] out_result_denominator;
  logic [FIELD_W-1:0]   out_whole_part;
  logic                 out_less;
  logic                 out_greater;
  logic                 out_equal;
  logic [ST_W-1:0]      out_status;

  frac_res_t expected_q[$];
  int        n_errors = 0;
  int        idle_cycles = 0;
  bit        gaps_on = 1'b1;   // random idling on both sides
  int        hold_off = 0;     // long receiver stall, counted down per cycle

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rational_arithmetic_unit i_dut (.*);

  // ---------------------------------------------------------------- predictor
  function automatic longint sx(logic [FIELD_W-1:0] v);
    logic [VALUE_WIDTH-1:0] lo;
    lo = v[VALUE_WIDTH-1:0];
    return longint'(signed'(lo));
  endfunction

  function automatic longint unsigned mag(longint x);
    return x < 0 ? longint'(0) - x : x;
  endfunction

  function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // reduce sign-magnitude num/den into r; den magnitude nonzero
  function automatic void reduce_frac(ref frac_res_t r, input bit nneg,
                                      input longint unsigned nm, input bit dneg,
                                      input longint unsigned dm);
    longint unsigned half, g, rn, rd;
    bit neg;
    half = 64'd1 << (VALUE_WIDTH - 1);
    if (nm == 0) return;
    g  = euclid(nm, dm);
    rn = nm / g;
    rd = dm / g;
    neg = nneg != dneg;
    if ((neg ? rn > half : rn > half - 1) || rd > half - 1) begin
      r.st = ST_OVERFLOW;
      return;
    end
    r.num = neg ? FIELD_W'(longint'(0) - longint'(rn)) : FIELD_W'(rn);
    r.den = DEN_OUT_W'(rd);
  endfunction

  // signed sum of two sign-magnitude products, kept as sign-magnitude
  function automatic void sm_sum(input bit xn, input longint unsigned xm, input bit yn,
                                 input longint unsigned ym, output bit sn,
                                 output longint unsigned sm);
    if (xn == yn) begin
      sn = xn; sm = xm + ym;
    end else if (xm >= ym) begin
      sn = xn; sm = xm - ym;
    end else begin
      sn = yn; sm = ym - xm;
    end
  endfunction

  function automatic frac_res_t predict_fraction(cmd_t c, logic [FIELD_W-1:0] an_f,
      logic [FIELD_W-1:0] ad_f, logic [FIELD_W-1:0] bn_f, logic [FIELD_W-1:0] bd_f);
    frac_res_t r;
    longint an, ad, bn, bd, nn, dd, q, rm, lim, l, rr;
    bit pn, qn, sn;
    longint unsigned pm, qm, sm;
    an = sx(an_f); ad = sx(ad_f); bn = sx(bn_f); bd = sx(bd_f);
    r = '{num: '0, den: 1, whole: '0, lt: 0, gt: 0, eq: 0, st: ST_OK};
    if (ad == 0 && c <= CMD_FLOOR) r.st = ST_ZERO_DEN;
    if (bd == 0 && c >= CMD_ADD && c <= CMD_CMP) r.st = ST_ZERO_DEN;
    if (c == CMD_DIV && bn == 0) r.st = ST_ZERO_DEN;
    if (r.st == ST_OK) begin
      case (c)
        CMD_NORM: reduce_frac(r, an < 0, mag(an), ad < 0, mag(ad));
        CMD_ADD, CMD_SUB: begin
          pn = (an < 0) != (bd < 0); pm = mag(an) * mag(bd);
          qn = (bn < 0) != (ad < 0); qm = mag(bn) * mag(ad);
          if (c == CMD_SUB) qn = !qn;
          sm_sum(pn, pm, qn, qm, sn, sm);
          reduce_frac(r, sn, sm, (ad < 0) != (bd < 0), mag(ad) * mag(bd));
        end
        CMD_MUL: reduce_frac(r, (an < 0) != (bn < 0), mag(an) * mag(bn),
                             (ad < 0) != (bd < 0), mag(ad) * mag(bd));
        CMD_DIV: reduce_frac(r, (an < 0) != (bd < 0), mag(an) * mag(bd),
                             (ad < 0) != (bn < 0), mag(ad) * mag(bn));
        CMD_CMP: begin
          l  = (ad < 0 ? -an : an) * (bd < 0 ? -bd : bd);
          rr = (bd < 0 ? -bn : bn) * (ad < 0 ? -ad : ad);
          r.lt = l < rr; r.gt = l > rr; r.eq = l == rr;
        end
        CMD_FLOOR: begin
          nn = ad < 0 ? -an : an;
          dd = ad < 0 ? -ad : ad;
          q = nn / dd; rm = nn % dd;
          lim = longint'(64'd1 << (VALUE_WIDTH - 1));
          if (rm < 0) begin
            q -= 1; rm += dd;
          end
          if (q < -lim || q > lim - 1) r.st = ST_OVERFLOW;
          else begin
            reduce_frac(r, 1'b0, rm, 1'b0, dd);
            if (r.st == ST_OK) r.whole = FIELD_W'(q);
          end
        end
        default: ;
      endcase
    end
    if (r.st != ST_OK) r = '{num: '0, den: 1, whole: '0, lt: 0, gt: 0, eq: 0, st: r.st};
    return r;
  endfunction

  // ---------------------------------------------------------------- driving
  // valid stays high between beats unless an idle burst is drawn
  task automatic send_fraction_pair(cmd_t c, logic [31:0] an, logic [31:0] ad,
                                    logic [31:0] bn, logic [31:0] bd);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= c;
    in_a_numerator   <= an;
    in_a_denominator <= ad;
    in_b_numerator   <= bn;
    in_b_denominator <= bd;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_fraction(c, an, ad, bn, bd));
  endtask

  // value biased towards the edges, small magnitudes and common factors
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 40)) - 20);
      3: return 32'($urandom_range(0, 1000)) * 32'($urandom_range(1, 64));
      4: return -(32'($urandom_range(1, 5000)) * 32'(1 << $urandom_range(0, 12)));
      5: return 32'(1) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    frac_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: num %h", $time,
                 out_result_numerator);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_result_numerator !== e.num) begin
          $display("%0t: numerator exp %h got %h", $time, e.num, out_result_numerator);
          n_errors++;
        end
        if (out_result_denominator !== e.den) begin
          $display("%0t: denominator exp %h got %h", $time, e.den, out_result_denominator);
          n_errors++;
        end
        if (out_whole_part !== e.whole) begin
          $display("%0t: whole part exp %h got %h", $time, e.whole, out_whole_part);
          n_errors++;
        end
        if ({out_less, out_greater, out_equal} !== {e.lt, e.gt, e.eq}) begin
          $display("%0t: compare flags exp %b%b%b got %b%b%b", $time, e.lt, e.gt, e.eq,
                   out_less, out_greater, out_equal);
          n_errors++;
        end
        if (out_status !== e.st) begin
          $display("%0t: status exp %0d got %0d", $time, e.st, out_status);
          n_errors++;
        end
      end
    end
  end

  // receiver: long hold-off when asked, otherwise random stall bursts
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off    <= hold_off - 1;
      out_stall   <= 1'b1;
    end else if (!gaps_on) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= ~out_stall;
    end
  end

  // watchdog: cycles with no beat accepted on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_edges();
    send_fraction_pair(CMD_NORM, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1);   // overflow
    send_fraction_pair(CMD_NORM, 6, -4, 0, 0);
    send_fraction_pair(CMD_NORM, 0, -7, 0, 0);                          // zero -> 0/1
    send_fraction_pair(CMD_NORM, 5, 0, 1, 1);                           // zero denominator
    send_fraction_pair(CMD_NORM, 1, 32'h8000_0000, 0, 0);               // den overflow
    send_fraction_pair(CMD_NORM, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send_fraction_pair(CMD_ADD, 1, 2, 1, 3);
    send_fraction_pair(CMD_ADD, 32'h7FFF_FFFF, 1, 1, 1);                 // overflow
    send_fraction_pair(CMD_ADD, 1, 2, 1, 0);
    send_fraction_pair(CMD_SUB, 1, 2, 1, 2);
    send_fraction_pair(CMD_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000);
    send_fraction_pair(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000);
    send_fraction_pair(CMD_MUL, -3, 4, 8, -9);
    send_fraction_pair(CMD_DIV, 1, 2, 0, 5);                            // divide by zero
    send_fraction_pair(CMD_DIV, -3, 4, 3, -8);
    send_fraction_pair(CMD_CMP, 1, 3, 2, 6);
    send_fraction_pair(CMD_CMP, -1, 3, 1, -4);
    send_fraction_pair(CMD_CMP, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1);
    send_fraction_pair(CMD_CMP, 1, 1, 1, 0);
    send_fraction_pair(CMD_FLOOR, -7, 2, 0, 0);
    send_fraction_pair(CMD_FLOOR, 7, -2, 0, 0);
    send_fraction_pair(CMD_FLOOR, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);  // whole overflows
    send_fraction_pair(CMD_FLOOR, 9, 3, 0, 0);
    send_fraction_pair(cmd_t'(7), 3, 0, 5, 0);                           // unused command
  endtask

  task automatic test_random(int n);
    repeat (n) send_fraction_pair(cmd_t'($urandom_range(0, 7)), pick_value(), pick_value(),
                                  pick_value(), pick_value());
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    hold_off = 600;
    test_random(12);
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edges();
    test_backpressure();
    test_random(1300);
    gaps_on = 1'b0;
    test_random(220);
    in_valid <= 1'b0;
    drain_results();
    repeat (400) @(posedge clk);   // margin after the last checked result
    if (n_errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
